// ----- sv/tdf_pkg.sv -----
// Package with the shared entry type and constants of the duplicate filter table.
`default_nettype none
package tdf_pkg;

  localparam int TABLE_DEPTH_DEF   = 32;
  localparam int ADDRESS_BYTES_DEF = 8;
  localparam int ADDR_W            = 64;
  localparam int LEN_W             = 4;
  localparam int EXP_W             = 49;
  localparam logic [31:0] HOLD_RESET = 32'd1000;

  typedef struct packed {
    logic [15:0]       seq;
    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0]  len;
    logic [EXP_W-1:0]  expiry;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXPIRE,
    ST_ACT,
    ST_OUT
  } state_t;

endpackage
`default_nettype wire

// ----- sv/tdf_cell.sv -----
// One table cell: holds one entry, shifts toward the oldest end, compares a key.
`default_nettype none
module tdf_cell
  import tdf_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   shift,
  input  wire logic   load,
  input  wire logic   live,
  input  wire entry_t neighbor,
  input  wire entry_t key,
  output entry_t      entry,
  output logic        match
);

  entry_t entry_r;

  always_ff @(posedge clk) begin
    if (load) begin
      entry_r <= key;
    end else if (shift) begin
      entry_r <= neighbor;
    end
  end

  assign entry = entry_r;
  assign match = live && (entry_r.seq == key.seq) && (entry_r.len == key.len) &&
                 (entry_r.addr == key.addr);

endmodule
`default_nettype wire

// ----- sv/timed_duplicate_filter_table_core.sv -----
// Top level of the timed duplicate filter table.
// Keys are held in a chain of cells in insertion order, the oldest in cell 0.
// An accepted request passes through the expire, act and output states; in the
// expire state each entry that has expired at its start is popped, the pops shifting
// the chain one place per cycle; the result is then held until taken, and the next
// word is accepted only once back in idle, never before the last result is taken.
`default_nettype none
module timed_duplicate_filter_table_core
  import tdf_pkg::*;
#(
  parameter int TABLE_DEPTH   = TABLE_DEPTH_DEF,
  parameter int ADDRESS_BYTES = ADDRESS_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_func,
  input  wire logic [15:0] in_sequence_id,
  input  wire logic [63:0] in_source_address,
  input  wire logic [7:0]  in_address_length,
  input  wire logic [47:0] in_now_ms,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_is_duplicate,
  output logic             out_was_added,
  output logic [5:0]       out_entries_held,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_hold_duration_ms
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);

  state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [31:0] hold_r;
  logic func_r, len_ok_r;
  logic [47:0] now_r;
  entry_t key_r;
  logic dup_r, dup_nxt, added_r, added_nxt;

  entry_t cell_q [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] match_v;
  logic shift, do_add, full;
  logic [ADDR_W-1:0] mask;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_OUT);
  assign out_is_duplicate = dup_r;
  assign out_was_added    = added_r;
  assign out_entries_held = 6'(count_r);
  assign full = (count_r == CW'(TABLE_DEPTH));

  always_comb begin
    for (int b = 0; b < 8; b++) begin
      mask[8*b +: 8] = ({24'd0, in_address_length} > b) ? 8'hff : 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= HOLD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      hold_r <= cfg_hold_duration_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      func_r      <= in_func;
      now_r       <= in_now_ms;
      len_ok_r    <= (in_address_length <= 8'(ADDRESS_BYTES));
      key_r.seq   <= in_sequence_id;
      key_r.addr  <= in_source_address & mask;
      key_r.len   <= LEN_W'(in_address_length);
      key_r.expiry <= EXP_W'({1'b0, in_now_ms}) + EXP_W'(hold_r);
    end
    if (state_r == ST_ACT) begin
      dup_r   <= dup_nxt;
      added_r <= added_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    shift     = 1'b0;
    do_add    = 1'b0;
    dup_nxt   = 1'b0;
    added_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_EXPIRE;
        end
      end
      ST_EXPIRE: begin
        if (count_r != '0 && {1'b0, now_r} >= cell_q[0].expiry) begin
          shift     = 1'b1;
          count_nxt = count_r - 1'b1;
        end else begin
          state_nxt = ST_ACT;
        end
      end
      ST_ACT: begin
        state_nxt = ST_OUT;
        if (!func_r) begin
          dup_nxt = len_ok_r && (|match_v);
        end else if (len_ok_r) begin
          do_add    = 1'b1;
          added_nxt = 1'b1;
          if (full) begin
            shift = 1'b1;
          end else begin
            count_nxt = count_r + 1'b1;
          end
        end
      end
      ST_OUT: begin
        if (!out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
    entry_t nb;
    logic   ld;
    if (k == TABLE_DEPTH - 1) begin : g_last
      assign nb = cell_q[k];
      assign ld = do_add && (full || count_r == CW'(k));
    end else begin : g_mid
      assign nb = cell_q[k+1];
      assign ld = do_add && !full && (count_r == CW'(k));
    end
    tdf_cell u_cell (
      .clk      (clk),
      .shift    (shift),
      .load     (ld),
      .live     (CW'(k) < count_r),
      .neighbor (nb),
      .key      (key_r),
      .entry    (cell_q[k]),
      .match    (match_v[k])
    );
  end

endmodule
`default_nettype wire

// ----- dv/tb_top.sv -----
// Self-checking testbench for the timed duplicate filter table core.
`timescale 1ns / 1ps
module tb_top;
  import tdf_pkg::*;

  localparam int DEPTH = 32;
  localparam int MAX_BYTES = 8;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic        func;
    logic [15:0] seq;
    logic [63:0] addr;
    logic [7:0]  len;
    logic [47:0] now;
  } request_t;

  typedef struct packed {
    logic       dup;
    logic       added;
    logic [5:0] held;
  } answer_t;

  localparam logic FN_CHECK = 1'b0;
  localparam logic FN_ADD   = 1'b1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_func = 1'b0;
  logic [15:0] in_sequence_id = '0;
  logic [63:0] in_source_address = '0;
  logic [7:0]  in_address_length = '0;
  logic [47:0] in_now_ms = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_is_duplicate;
  logic out_was_added;
  logic [5:0] out_entries_held;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [31:0] cfg_hold_duration_ms = '0;

  always #1 clk = ~clk;

  timed_duplicate_filter_table_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_func(in_func),
    .in_sequence_id(in_sequence_id), .in_source_address(in_source_address),
    .in_address_length(in_address_length), .in_now_ms(in_now_ms),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_is_duplicate(out_is_duplicate), .out_was_added(out_was_added),
    .out_entries_held(out_entries_held),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_hold_duration_ms(cfg_hold_duration_ms)
  );

  // Predictor copy of the table, oldest entry at key_head.
  logic [15:0] key_seq [DEPTH];
  logic [63:0] key_addr [DEPTH];
  logic [7:0]  key_len [DEPTH];
  logic [48:0] key_expiry [DEPTH];
  int unsigned key_head = 0;
  int unsigned key_count = 0;
  logic [31:0] hold_ms = HOLD_RESET;

  request_t pending_words[$];
  answer_t  expected_answers[$];
  int mismatches = 0;
  int answers_seen = 0;
  int dup_hits = 0;
  int idle_cycles = 0;
  bit hold_sender = 1'b0;
  bit in_taken = 1'b0;
  logic [47:0] clock_ms = 48'd5;

  function automatic logic [63:0] len_mask(input logic [7:0] nbytes);
    if (nbytes >= 8) return '1;
    return (64'd1 << (8 * nbytes)) - 64'd1;
  endfunction

  function automatic answer_t filter_predict(input request_t rq);
    answer_t a;
    int unsigned slot;
    a = '0;
    while (key_count > 0 && {1'b0, rq.now} >= key_expiry[key_head]) begin
      key_head = (key_head + 1) % DEPTH;
      key_count--;
    end
    if (rq.func == FN_CHECK) begin
      if (rq.len <= MAX_BYTES) begin
        for (int i = 0; i < key_count; i++) begin
          slot = (key_head + i) % DEPTH;
          if (key_seq[slot] == rq.seq && key_len[slot] == rq.len &&
              key_addr[slot] == (rq.addr & len_mask(rq.len))) a.dup = 1'b1;
        end
      end
    end else if (rq.len <= MAX_BYTES) begin
      if (key_count >= DEPTH) begin
        key_head = (key_head + 1) % DEPTH;
        key_count = DEPTH - 1;
      end
      slot = (key_head + key_count) % DEPTH;
      key_seq[slot] = rq.seq;
      key_addr[slot] = rq.addr & len_mask(rq.len);
      key_len[slot] = rq.len;
      key_expiry[slot] = {1'b0, rq.now} + {17'd0, hold_ms};
      key_count++;
      a.added = 1'b1;
    end
    a.held = key_count[5:0];
    return a;
  endfunction

  // Driver: bursts of words with random gaps in between. A word is held until
  // the rising edge before has taken it.
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (!hold_sender && pending_words.size() > 0) begin
        request_t rq;
        rq = pending_words.pop_front();
        in_valid <= 1'b1;
        in_func <= rq.func;
        in_sequence_id <= rq.seq;
        in_source_address <= rq.addr;
        in_address_length <= rq.len;
        in_now_ms <= rq.now;
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 20);
        end else if (burst_left == 1) begin
          burst_left <= 0;
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall pattern: a stall-free phase, then a light-stall and a heavy-stall phase, repeating.
  int stall_phase = 0;
  always @(negedge clk) begin
    stall_phase <= (stall_phase + 1) % 400;
    if (stall_phase < 150) out_stall <= 1'b0;
    else if (stall_phase < 300) out_stall <= ($urandom_range(0, 3) == 0);
    else out_stall <= ($urandom_range(0, 1) == 0);
  end

  // Monitor, predictor hookup and watchdog.
  always @(posedge clk) begin
    answer_t got;
    answer_t want;
    request_t rq;
    in_taken <= in_valid && !in_stall;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        rq = {in_func, in_sequence_id, in_source_address, in_address_length, in_now_ms};
        expected_answers.push_back(filter_predict(rq));
      end
      if (out_valid && !out_stall) begin
        got = {out_is_duplicate, out_was_added, out_entries_held};
        answers_seen++;
        if (got.dup) dup_hits++;
        if (expected_answers.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected result word %h", got);
        end else begin
          want = expected_answers.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Result %0d: dup %b/%b added %b/%b held %0d/%0d (exp/act)",
                       answers_seen, want.dup, got.dup, want.added, got.added,
                       want.held, got.held);
          end
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_valid)
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no progress, %0d results outstanding", expected_answers.size());
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic wait_drained();
    while (pending_words.size() > 0 || in_valid || expected_answers.size() > 0)
      @(posedge clk);
    repeat (DEPTH + 10) @(posedge clk);
  endtask

  task automatic write_hold(input logic [31:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_hold_duration_ms <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    hold_ms = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic request_t make_word(input logic fn, input logic [15:0] sq,
                                         input logic [63:0] ad, input logic [7:0] ln,
                                         input logic [47:0] tm);
    request_t rq;
    rq.func = fn; rq.seq = sq; rq.addr = ad; rq.len = ln; rq.now = tm;
    return rq;
  endfunction

  // Random word drawn mostly from a small key pool so checks find live entries.
  function automatic request_t random_word();
    request_t rq;
    logic [7:0] ln;
    ln = ($urandom_range(0, 15) == 0) ? 8'($urandom_range(9, 255)) : 8'($urandom_range(0, 8));
    rq.func = $urandom_range(0, 1);
    rq.seq = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 7));
    rq.addr = ($urandom_range(0, 1) == 0) ? {$urandom, $urandom}
                                          : {32'hA5A5_0000, 32'($urandom_range(0, 3))};
    rq.len = ln;
    clock_ms = clock_ms + 48'($urandom_range(0, 60));
    rq.now = clock_ms;
    return rq;
  endfunction

  task automatic random_phase(input int count);
    for (int i = 0; i < count; i++) begin
      pending_words.push_back(random_word());
      if (i % 64 == 63) while (pending_words.size() > 8) @(posedge clk);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // Directed: extremes, both operations, too long, zero length, expiry, a run of adds.
    pending_words.push_back(make_word(FN_ADD, 16'hFFFF, '1, 8'd8, 48'd10));
    pending_words.push_back(make_word(FN_CHECK, 16'hFFFF, '1, 8'd8, 48'd11));
    pending_words.push_back(make_word(FN_ADD, 16'h0, '1, 8'd0, 48'd12));
    pending_words.push_back(make_word(FN_CHECK, 16'h0, 64'h1234, 8'd0, 48'd13));
    pending_words.push_back(make_word(FN_ADD, 16'h5, 64'hFFEE_DDCC_BBAA_9988, 8'd3, 48'd14));
    pending_words.push_back(make_word(FN_CHECK, 16'h5, 64'h0000_0000_00AA_9988, 8'd3, 48'd15));
    pending_words.push_back(make_word(FN_ADD, 16'h7, '1, 8'd9, 48'd16));
    pending_words.push_back(make_word(FN_CHECK, 16'h7, '1, 8'd255, 48'd17));
    pending_words.push_back(make_word(FN_CHECK, 16'hFFFF, '1, 8'd8, 48'd1010));
    for (int i = 0; i < 12; i++)
      pending_words.push_back(make_word(FN_ADD, 16'(i), 64'(i), 8'd1, 48'd1100));
    pending_words.push_back(make_word(FN_CHECK, 16'd0, 64'd0, 8'd1, 48'd1101));
    wait_drained();
    clock_ms = 48'd2000;
    random_phase(476);
    // Sender holds off until everything is answered, then a tiny hold forces expiry pops.
    wait_drained();
    write_hold(32'd0);
    random_phase(150);
    wait_drained();
    write_hold(32'd3);
    random_phase(250);
    wait_drained();
    // Huge hold: keys never expire, so the table fills and evicts.
    write_hold(32'hFFFF_FFFF);
    random_phase(250);
    wait_drained();
    write_hold(32'd200);
    random_phase(200);
    // Time near the top of the range exercises the widened expiry sum.
    pending_words.push_back(make_word(FN_ADD, 16'h1, 64'h1, 8'd1, 48'hFFFF_FFFF_FFF0));
    pending_words.push_back(make_word(FN_CHECK, 16'h1, 64'h1, 8'd1, 48'hFFFF_FFFF_FFFF));
    wait_drained();
    write_hold(HOLD_RESET);
    $display("Ran %0d results (%0d duplicates seen) across hold settings 0, 3, 200, 1000 and max.",
             answers_seen, dup_hits);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Verification failed");
    end
    $finish;
  end

endmodule
